@@ hw/rtl/fq_pkg.sv @@
// ----------------------------------------------------------------------------
// fq_pkg
// Shared types, constants and helpers for the FIFO queue with search.
// ----------------------------------------------------------------------------
package fq_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_WIDTH = 16;
  localparam int PORT_W   = 16;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_SRCH = 2'd2,
    CMD_DISP = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5,
    ST_LISTED    = 3'd6
  } status_t;

  // One result between the sequencer and the output register
  typedef struct packed {
    status_t             status;
    logic [PORT_W-1:0]   id;
    logic                last;
  } res_t;

  // Port id -> stored id (keeps the low ID_WIDTH bits)
  function automatic logic [ID_WIDTH-1:0] id_from_port(logic [PORT_W-1:0] v);
    logic [ID_WIDTH+PORT_W-1:0] w;
    w = {{ID_WIDTH{1'b0}}, v};
    return w[ID_WIDTH-1:0];
  endfunction

  // Stored id -> port id (zero extend or truncate)
  function automatic logic [PORT_W-1:0] id_to_port(logic [ID_WIDTH-1:0] v);
    logic [ID_WIDTH+PORT_W-1:0] w;
    w = {{PORT_W{1'b0}}, v};
    return w[PORT_W-1:0];
  endfunction

  // Circular index advance
  function automatic logic [ADDR_W-1:0] next_slot(logic [ADDR_W-1:0] i);
    if (i == ADDR_W'(DEPTH - 1)) begin
      return '0;
    end
    return i + ADDR_W'(1);
  endfunction

endpackage

@@ hw/rtl/fq_if.sv @@
// ----------------------------------------------------------------------------
// fq_in_if / fq_out_if
// Valid/ready channels for command requests and result requests.
// ----------------------------------------------------------------------------
interface fq_in_if;
  logic                           valid;
  logic                           ready;
  fq_pkg::cmd_t                   cmd;
  logic [fq_pkg::PORT_W-1:0]      item_id;

  modport source (output valid, output cmd, output item_id, input ready);
  modport sink   (input valid, input cmd, input item_id, output ready);
endinterface

interface fq_out_if;
  logic                           valid;
  logic                           ready;
  fq_pkg::status_t                status;
  logic [fq_pkg::PORT_W-1:0]      result_id;
  logic                           last;

  modport source (output valid, output status, output result_id, output last, input ready);
  modport sink   (input valid, input status, input result_id, input last, output ready);
endinterface

@@ hw/rtl/fq_ram.sv @@
// ----------------------------------------------------------------------------
// fq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module fq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/fq_oreg.sv @@
// ----------------------------------------------------------------------------
// fq_oreg
// Output register: holds one result request until the sink takes it.
// ----------------------------------------------------------------------------
module fq_oreg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  fq_pkg::res_t push_res,
  output logic         push_ok,
  fq_out_if.source     out_ch
);
  import fq_pkg::*;

  logic valid_r;
  res_t res_r;

  assign push_ok = !valid_r || out_ch.ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ok) begin
      valid_r <= push;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push && push_ok) begin
      res_r <= push_res;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.status    = res_r.status;
  assign out_ch.result_id = res_r.id;
  assign out_ch.last      = res_r.last;

endmodule

@@ hw/rtl/fq_ctrl.sv @@
// ----------------------------------------------------------------------------
// fq_ctrl
// Command sequencer: owns head/tail/occupancy, drives the RAM and walks the
// stored entries for search and display.
// ----------------------------------------------------------------------------
module fq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  fq_in_if.sink                       in_ch,
  output logic                        ram_we,
  output logic [fq_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [fq_pkg::ID_WIDTH-1:0] ram_wdata,
  output logic                        ram_re,
  output logic [fq_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [fq_pkg::ID_WIDTH-1:0] ram_rdata,
  output logic                        push,
  output fq_pkg::res_t                push_res,
  input  logic                        push_ok
);
  import fq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_SCAN,
    S_LIST
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [ADDR_W-1:0]   slot_r, slot_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [ID_WIDTH-1:0] key_r, key_nxt;
  cmd_t                cmd_r, cmd_nxt;
  res_t                res_r, res_nxt;

  logic [ID_WIDTH-1:0] key_in;
  logic                accept;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign key_in      = id_from_port(in_ch.item_id);

  // Next-state and datapath control
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    slot_nxt  = slot_r;
    rem_nxt   = rem_r;
    key_nxt   = key_r;
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = key_in;
    ram_re    = 1'b0;
    ram_raddr = slot_r;
    push      = 1'b0;
    push_res  = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_ch.cmd;
          key_nxt  = key_in;
          slot_nxt = next_slot(head_r);
          rem_nxt  = occ_r;
          unique case (in_ch.cmd)
            CMD_ENQ: begin
              state_nxt = S_EMIT;
              if (occ_r == CNT_W'(DEPTH)) begin
                res_nxt = '{status: ST_FULL, id: id_to_port(key_in), last: 1'b1};
              end else begin
                ram_we   = 1'b1;
                tail_nxt = next_slot(tail_r);
                occ_nxt  = occ_r + CNT_W'(1);
                res_nxt  = '{status: ST_ADDED, id: id_to_port(key_in), last: 1'b1};
              end
            end
            CMD_DEQ: begin
              if (occ_r == '0) begin
                state_nxt = S_EMIT;
                res_nxt   = '{status: ST_EMPTY, id: '0, last: 1'b1};
              end else begin
                state_nxt = S_LIST;
                ram_re    = 1'b1;
                ram_raddr = head_r;
                head_nxt  = next_slot(head_r);
                occ_nxt   = occ_r - CNT_W'(1);
                rem_nxt   = CNT_W'(1);
              end
            end
            CMD_SRCH: begin
              if (occ_r == '0) begin
                state_nxt = S_EMIT;
                res_nxt   = '{status: ST_NOT_FOUND, id: id_to_port(key_in), last: 1'b1};
              end else begin
                state_nxt = S_SCAN;
                ram_re    = 1'b1;
                ram_raddr = head_r;
              end
            end
            CMD_DISP: begin
              if (occ_r == '0) begin
                state_nxt = S_EMIT;
                res_nxt   = '{status: ST_EMPTY, id: '0, last: 1'b1};
              end else begin
                state_nxt = S_LIST;
                ram_re    = 1'b1;
                ram_raddr = head_r;
              end
            end
            default: ;
          endcase
        end
      end

      // Single result waiting for the output register
      S_EMIT: begin
        push = 1'b1;
        if (push_ok) begin
          state_nxt = S_IDLE;
        end
      end

      // One compare per cycle; next read already in flight
      S_SCAN: begin
        if (ram_rdata == key_r) begin
          state_nxt = S_EMIT;
          res_nxt   = '{status: ST_FOUND, id: id_to_port(key_r), last: 1'b1};
        end else if (rem_r == CNT_W'(1)) begin
          state_nxt = S_EMIT;
          res_nxt   = '{status: ST_NOT_FOUND, id: id_to_port(key_r), last: 1'b1};
        end else begin
          ram_re   = 1'b1;
          slot_nxt = next_slot(slot_r);
          rem_nxt  = rem_r - CNT_W'(1);
        end
      end

      // Stream read data out; read data holds while stalled
      S_LIST: begin
        push     = 1'b1;
        push_res = '{status: (cmd_r == CMD_DEQ) ? ST_REMOVED : ST_LISTED,
                     id:     id_to_port(ram_rdata),
                     last:   (rem_r == CNT_W'(1))};
        if (push_ok) begin
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re   = 1'b1;
            slot_nxt = next_slot(slot_r);
            rem_nxt  = rem_r - CNT_W'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
    end
    slot_r <= slot_nxt;
    rem_r  <= rem_nxt;
    key_r  <= key_nxt;
    cmd_r  <= cmd_nxt;
    res_r  <= res_nxt;
  end

endmodule

@@ hw/rtl/fifo_queue_with_search.sv @@
// Enqueue, dequeue and empty results wait in the sequencer's emit or list state
// until the output register takes them; search does one RAM read and one compare
// per cycle, pipelined, until a match or the last stored entry; display streams
// occupancy results, one a cycle while the output is not stalled.
// Throughput: one request at a time; the next is taken the cycle after the last
// result enters the output register. Reset clears pointers, count and out valid.
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// Bounded FIFO of ids with enqueue, dequeue, linear search and display.
// ----------------------------------------------------------------------------
module fifo_queue_with_search (
  input  logic       clk,
  input  logic       rst_n,
  fq_in_if.sink      in_ch,
  fq_out_if.source   out_ch
);
  import fq_pkg::*;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ID_WIDTH-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ID_WIDTH-1:0] ram_rdata;
  logic                push;
  res_t                push_res;
  logic                push_ok;

  // Id store
  fq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ID_WIDTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Command sequencer
  fq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .push     (push),
    .push_res (push_res),
    .push_ok  (push_ok)
  );

  // Output register
  fq_oreg u_oreg (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_res(push_res),
    .push_ok (push_ok),
    .out_ch  (out_ch)
  );

endmodule

@@ hw/rtl/fq_chk.sv @@
// ----------------------------------------------------------------------------
// fq_chk
// Port-level checks for the FIFO queue with search, bound to the top level.
// ----------------------------------------------------------------------------
module fq_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic       out_last
);
  import fq_pkg::*;

  // A result request stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // Only one request is in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while one is in work");

  // Only display listings span several results
  a_multi_is_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == 3'(ST_LISTED))
    else $error("non-final result that is not a listed entry");

  // An idle block with an empty output keeps the output empty next cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without a request");

endmodule

bind fifo_queue_with_search fq_chk u_fq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_status(out_ch.status),
  .out_last  (out_ch.last)
);
